FILE: rtl/mrac_pkg.sv
`default_nettype none

package mrac_pkg;

    localparam int ADDR_W   = 32;
    localparam int WORD_W   = 32;
    localparam int MASTER_W = 3;
    localparam int ACC_W    = 2;
    localparam int RIDX_W   = 4;
    localparam int WSEL_W   = 2;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_DESC  = 1'b1;

    localparam logic [ACC_W-1:0] ACC_READ    = 2'd0;
    localparam logic [ACC_W-1:0] ACC_WRITE   = 2'd1;
    localparam logic [ACC_W-1:0] ACC_EXEC    = 2'd2;
    localparam logic [ACC_W-1:0] ACC_INVALID = 2'd3;

    localparam logic [WSEL_W-1:0] WSEL_START = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_END   = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_ACL   = 2'd2;
    localparam logic [WSEL_W-1:0] WSEL_VALID = 2'd3;

    localparam logic [1:0] MODE_RWX  = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_RW   = 2'd2;
    localparam logic [1:0] MODE_USER = 2'd3;

    localparam int   FIELD_W      = 6;
    localparam int   BUS_EN_BASE  = 24;

    localparam int   CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   address;
        logic [MASTER_W-1:0] master;
        logic                supervisor;
        logic [ACC_W-1:0]    access_type;
        logic [RIDX_W-1:0]   region_index;
        logic [WSEL_W-1:0]   word_select;
        logic [WORD_W-1:0]   word_value;
    } t_in_item;

    typedef struct packed {
        logic                allowed;
        logic                violation;
        logic                error_flag;
        logic [ADDR_W-1:0]   error_address;
        logic [MASTER_W-1:0] error_master;
        logic [ACC_W-1:0]    error_access;
    } t_out_item;

    typedef struct packed {
        logic                en;
        logic [RIDX_W-1:0]   idx;
        logic [WSEL_W-1:0]   sel;
        logic [WORD_W-1:0]   data;
    } t_desc_wr;

    typedef struct packed {
        logic [WORD_W-1:0] lo_addr;
        logic [WORD_W-1:0] hi_addr;
        logic [WORD_W-1:0] acl;
        logic              valid;
    } t_region;

endpackage

`default_nettype wire

FILE: rtl/mrac_region_store.sv
`default_nettype none

module mrac_region_store #(
    parameter int REGION_COUNT = 12
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mrac_pkg::t_desc_wr    i_wr,
    input  wire                   i_rd_en,
    input  wire [((REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1)-1:0] i_rd_addr,
    output mrac_pkg::t_region     o_region
);
    import mrac_pkg::*;

    localparam int RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

    logic [WORD_W-1:0] m_lo  [REGION_COUNT];
    logic [WORD_W-1:0] m_hi  [REGION_COUNT];
    logic [WORD_W-1:0] m_acl [REGION_COUNT];

    logic [REGION_COUNT-1:0] r_lo_wr;
    logic [REGION_COUNT-1:0] r_hi_wr;
    logic [REGION_COUNT-1:0] r_acl_wr;
    logic [REGION_COUNT-1:0] r_valid;

    logic [WORD_W-1:0] r_lo_q;
    logic [WORD_W-1:0] r_hi_q;
    logic [WORD_W-1:0] r_acl_q;
    logic              r_lo_ok;
    logic              r_hi_ok;
    logic              r_acl_ok;
    logic              r_valid_q;

    logic [RW-1:0] wr_addr;
    logic          wr_ok;

    assign wr_addr = i_wr.idx[RW-1:0];
    assign wr_ok   = i_wr.en && (32'(i_wr.idx) < REGION_COUNT);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            case (i_wr.sel)
                WSEL_START: m_lo[wr_addr]  <= i_wr.data;
                WSEL_END:   m_hi[wr_addr]  <= i_wr.data;
                WSEL_ACL:   m_acl[wr_addr] <= i_wr.data;
                default: ;
            endcase
        end
        if (i_rd_en) begin
            r_lo_q  <= m_lo[i_rd_addr];
            r_hi_q  <= m_hi[i_rd_addr];
            r_acl_q <= m_acl[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_wr   <= '0;
            r_hi_wr   <= '0;
            r_acl_wr  <= '0;
            r_valid   <= '0;
            r_lo_ok   <= 1'b0;
            r_hi_ok   <= 1'b0;
            r_acl_ok  <= 1'b0;
            r_valid_q <= 1'b0;
        end else begin
            if (wr_ok) begin
                case (i_wr.sel)
                    WSEL_START: r_lo_wr[wr_addr]  <= 1'b1;
                    WSEL_END:   r_hi_wr[wr_addr]  <= 1'b1;
                    WSEL_ACL:   r_acl_wr[wr_addr] <= 1'b1;
                    WSEL_VALID: r_valid[wr_addr]  <= i_wr.data[0];
                    default: ;
                endcase
            end
            if (i_rd_en) begin
                r_lo_ok   <= r_lo_wr[i_rd_addr];
                r_hi_ok   <= r_hi_wr[i_rd_addr];
                r_acl_ok  <= r_acl_wr[i_rd_addr];
                r_valid_q <= r_valid[i_rd_addr];
            end
        end
    end

    // words not written since reset read as zero
    assign o_region.lo_addr = r_lo_ok  ? r_lo_q  : '0;
    assign o_region.hi_addr = r_hi_ok  ? r_hi_q  : '0;
    assign o_region.acl     = r_acl_ok ? r_acl_q : '0;
    assign o_region.valid   = r_valid_q;

endmodule

`default_nettype wire

FILE: rtl/mrac_match_unit.sv
`default_nettype none

module mrac_match_unit (
    input  wire [mrac_pkg::ADDR_W-1:0]   i_address,
    input  wire [mrac_pkg::MASTER_W-1:0] i_master,
    input  wire                          i_supervisor,
    input  wire [mrac_pkg::ACC_W-1:0]    i_access_type,
    input  mrac_pkg::t_region            i_region,
    output logic                         o_hit
);
    import mrac_pkg::*;

    logic [FIELD_W-1:0] field;
    logic [1:0]         bus_en;
    logic               user_ok;
    logic               perm;
    logic               in_range;

    always_comb begin
        case (i_master[1:0])
            2'd0:    field = i_region.acl[0*FIELD_W +: FIELD_W];
            2'd1:    field = i_region.acl[1*FIELD_W +: FIELD_W];
            2'd2:    field = i_region.acl[2*FIELD_W +: FIELD_W];
            default: field = i_region.acl[3*FIELD_W +: FIELD_W];
        endcase
        bus_en = i_region.acl[BUS_EN_BASE + 2*i_master[1:0] +: 2];

        case (i_access_type)
            ACC_READ:  user_ok = field[2];
            ACC_WRITE: user_ok = field[1];
            default:   user_ok = field[0];
        endcase

        if (!i_master[2]) begin
            if (!i_supervisor) begin
                perm = user_ok;
            end else begin
                case (field[4:3])
                    MODE_RWX: perm = 1'b1;
                    MODE_RX:  perm = (i_access_type != ACC_WRITE);
                    MODE_RW:  perm = (i_access_type != ACC_EXEC);
                    default:  perm = user_ok;
                endcase
            end
        end else begin
            case (i_access_type)
                ACC_READ:  perm = bus_en[1];
                ACC_WRITE: perm = bus_en[0];
                default:   perm = 1'b0;
            endcase
        end

        in_range = (i_address >= i_region.lo_addr) && (i_address <= i_region.hi_addr);
        o_hit    = i_region.valid && in_range && perm;
    end

endmodule

`default_nettype wire

FILE: rtl/mpu_region_access_check_unit.sv
// Channel    Handshake                   Payload
// in         i_in_valid / o_in_stall     i_in  (t_in_item)
// out        o_out_valid / i_out_stall   o_out (t_out_item)
// cfg        i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A descriptor write, or an access decided without a scan, goes from idle straight to the done state.
// A scanned access reads and compares one region per cycle through the
// shared match unit, lets the last read drain, then loads the result when
// the result register is not held by a stall, and returns to idle.
// Reset clears the region table's valid and written flags, the error record and the sequencer.
// The result register lets the next transfer in while a result is stalled.
`default_nettype none

module mpu_region_access_check_unit #(
    parameter int REGION_COUNT = 12,
    parameter int MASTER_COUNT = 8
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  mrac_pkg::t_in_item               i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output mrac_pkg::t_out_item              o_out,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [mrac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire                              i_cfg_data
);
    import mrac_pkg::*;

    localparam int RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int CW = $clog2(REGION_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pend;
    logic          r_allow, n_allow;
    logic          r_scan, n_scan;
    t_in_item      r_item;

    logic                r_avail;
    logic                r_enable;
    logic                r_err;
    logic [ADDR_W-1:0]   r_err_addr;
    logic [MASTER_W-1:0] r_err_master;
    logic [ACC_W-1:0]    r_err_acc;

    t_out_item r_out;
    logic      r_out_vld;

    t_desc_wr  desc_wr;
    t_region   region;
    logic      in_acc;
    logic      scan_more;
    logic      rd_en;
    logic      hit;
    logic      load;
    logic      viol;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign scan_more = r_cnt < CW'(REGION_COUNT);
    assign rd_en     = (r_state == S_SCAN) && scan_more;
    assign load      = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign viol      = r_scan && !r_allow;

    assign desc_wr.en   = in_acc && (i_in.kind == KIND_DESC);
    assign desc_wr.idx  = i_in.region_index;
    assign desc_wr.sel  = i_in.word_select;
    assign desc_wr.data = i_in.word_value;

    mrac_region_store #(
        .REGION_COUNT (REGION_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (desc_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt[RW-1:0]),
        .o_region  (region)
    );

    mrac_match_unit u_match (
        .i_address     (r_item.address),
        .i_master      (r_item.master),
        .i_supervisor  (r_item.supervisor),
        .i_access_type (r_item.access_type),
        .i_region      (region),
        .o_hit         (hit)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_allow = r_allow;
        n_scan  = r_scan;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cnt   = '0;
                    n_allow = 1'b0;
                    n_scan  = 1'b0;
                    n_state = S_DONE;
                    if (i_in.kind == KIND_CHECK) begin
                        if (i_in.access_type == ACC_INVALID
                            || 32'(i_in.master) >= MASTER_COUNT || !r_avail) begin
                            n_allow = 1'b0;
                        end else if (!r_enable) begin
                            n_allow = 1'b1;
                        end else begin
                            n_scan  = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_pend && hit) begin
                    n_allow = 1'b1;
                end
                if (!scan_more && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_allow      <= 1'b0;
            r_scan       <= 1'b0;
            r_avail      <= 1'b1;
            r_enable     <= 1'b1;
            r_err        <= 1'b0;
            r_err_addr   <= '0;
            r_err_master <= '0;
            r_err_acc    <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= rd_en;
            r_allow <= n_allow;
            r_scan  <= n_scan;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_AVAIL:  r_avail  <= i_cfg_data;
                    CFG_ENABLE: r_enable <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load && viol) begin
                r_err        <= 1'b1;
                r_err_addr   <= r_item.address;
                r_err_master <= r_item.master;
                r_err_acc    <= r_item.access_type;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in;
        end
        if (load) begin
            r_out.allowed       <= r_allow;
            r_out.violation     <= viol;
            r_out.error_flag    <= r_err || viol;
            r_out.error_address <= viol ? r_item.address     : r_err_addr;
            r_out.error_master  <= viol ? r_item.master      : r_err_master;
            r_out.error_access  <= viol ? r_item.access_type : r_err_acc;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/mrac_checker.sv
`default_nettype none

module mrac_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input mrac_pkg::t_out_item o_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // one item at a time: busy right after a transfer in
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_viol_denied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.violation && o_out.allowed))
        else $error("violation on an allowed access");

    a_viol_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.violation |-> o_out.error_flag)
        else $error("violation without error flag");

    // error flag is only cleared by reset
    a_flag_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error_flag |=> o_out.error_flag)
        else $error("sticky error flag dropped");

endmodule

bind mpu_region_access_check_unit mrac_checker u_mrac_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

import mrac_pkg::*;

localparam int NUM_REGIONS = 12;
localparam int NUM_MASTERS = 8;
localparam int IDLE_LIMIT  = 1000;

class mpu_scoreboard;
    logic        unit_on;
    logic        check_on;
    t_region     regions[NUM_REGIONS];
    logic        err_sticky;
    logic [31:0] err_addr;
    logic [2:0]  err_master;
    logic [1:0]  err_acc;
    t_out_item   expected_q[$];
    bit          seen_setting[4];
    int          mismatches;
    int          n_access;
    int          n_desc;
    int          n_allowed;
    int          n_violations;
    int          n_results;

    function new();
        unit_on    = 1'b1;
        check_on   = 1'b1;
        foreach (regions[i]) regions[i] = '0;
        err_sticky = 1'b0;
        err_addr   = '0;
        err_master = '0;
        err_acc    = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic data);
        if (idx == CFG_AVAIL) begin
            unit_on = data;
        end else if (idx == CFG_ENABLE) begin
            check_on = data;
        end
    endfunction

    // permission decode of one access-control word
    function bit grants(logic [31:0] acl, logic [2:0] m, logic sup, logic [1:0] acc);
        int         mi;
        int         s;
        int         bitpos;
        logic [2:0] user;
        logic       user_ok;
        logic [1:0] mode;
        mi = int'(m);
        if (mi < 4) begin
            s       = mi * FIELD_W;
            user    = acl[s +: 3];
            user_ok = user[2 - int'(acc)];
            mode    = acl[s + 3 +: 2];
            if (!sup) return user_ok;
            case (mode)
                MODE_RWX: return 1'b1;
                MODE_RX:  return acc != ACC_WRITE;
                MODE_RW:  return acc != ACC_EXEC;
                default:  return user_ok;
            endcase
        end
        if (acc == ACC_EXEC) return 1'b0;
        bitpos = BUS_EN_BASE + (mi - 4) * 2 + ((acc == ACC_WRITE) ? 0 : 1);
        return acl[bitpos];
    endfunction

    function void note_input(t_in_item it);
        t_out_item exp;
        exp = '0;
        if (it.kind == KIND_DESC) begin
            n_desc++;
            if (int'(it.region_index) < NUM_REGIONS) begin
                case (it.word_select)
                    WSEL_START: regions[it.region_index].lo_addr = it.word_value;
                    WSEL_END:   regions[it.region_index].hi_addr = it.word_value;
                    WSEL_ACL:   regions[it.region_index].acl     = it.word_value;
                    default:    regions[it.region_index].valid   = it.word_value[0];
                endcase
            end
        end else begin
            n_access++;
            seen_setting[{unit_on, check_on}] = 1'b1;
            if (it.access_type == ACC_INVALID || int'(it.master) >= NUM_MASTERS || !unit_on) begin
                exp.allowed = 1'b0;
            end else if (!check_on) begin
                exp.allowed = 1'b1;
            end else begin
                for (int r = 0; r < NUM_REGIONS && !exp.allowed; r++) begin
                    if (regions[r].valid && it.address >= regions[r].lo_addr &&
                        it.address <= regions[r].hi_addr &&
                        grants(regions[r].acl, it.master, it.supervisor, it.access_type))
                        exp.allowed = 1'b1;
                end
                if (!exp.allowed) begin
                    exp.violation = 1'b1;
                    err_sticky    = 1'b1;
                    err_addr      = it.address;
                    err_master    = it.master;
                    err_acc       = it.access_type;
                    n_violations++;
                end
            end
            if (exp.allowed) n_allowed++;
        end
        exp.error_flag    = err_sticky;
        exp.error_address = err_addr;
        exp.error_master  = err_master;
        exp.error_access  = err_acc;
        expected_q.push_back(exp);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item exp;
        if (expected_q.size() == 0) begin
            $display("%0t: result with no transfer pending, expected none, actual %p", $time, got);
            mismatches++;
            return;
        end
        exp = expected_q.pop_front();
        n_results++;
        cmp_field("allowed",       32'(exp.allowed),       32'(got.allowed));
        cmp_field("violation",     32'(exp.violation),     32'(got.violation));
        cmp_field("error_flag",    32'(exp.error_flag),    32'(got.error_flag));
        cmp_field("error_address", exp.error_address,      got.error_address);
        cmp_field("error_master",  32'(exp.error_master),  32'(got.error_master));
        cmp_field("error_access",  32'(exp.error_access),  32'(got.error_access));
    endfunction
endclass

module tb;
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic                  i_cfg_data;

    mpu_scoreboard sb = new();

    int burst_left;
    int n_sent;
    int idle_cycles;
    bit moved;
    int stall_run;
    int stall_clock;
    bit calm;

    mpu_region_access_check_unit #(
        .REGION_COUNT(NUM_REGIONS),
        .MASTER_COUNT(NUM_MASTERS)
    ) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, %0d cycles without a transfer", $time, IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
    end

    // output stall pattern: calm stretches and stretches of random stall runs
    always @(posedge i_clk) begin
        stall_clock++;
        if (stall_clock % 300 == 0) calm = ($urandom_range(0, 2) == 0);
        if (stall_run > 0) begin
            stall_run--;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_run = $urandom_range(1, 12);
        end
        i_out_stall <= (stall_run > 0);
    end

    function automatic t_in_item noise_item();
        t_in_item it;
        it.kind         = 1'($urandom());
        it.address      = $urandom();
        it.master       = 3'($urandom());
        it.supervisor   = 1'($urandom());
        it.access_type  = 2'($urandom());
        it.region_index = 4'($urandom());
        it.word_select  = 2'($urandom());
        it.word_value   = $urandom();
        return it;
    endfunction

    function automatic t_in_item make_access(logic [31:0] addr, logic [2:0] m, logic sup,
                                             logic [1:0] acc);
        t_in_item it;
        it             = noise_item();
        it.kind        = KIND_CHECK;
        it.address     = addr;
        it.master      = m;
        it.supervisor  = sup;
        it.access_type = acc;
        return it;
    endfunction

    function automatic t_in_item make_desc(logic [3:0] ridx, logic [1:0] wsel, logic [31:0] val);
        t_in_item it;
        it              = noise_item();
        it.kind         = KIND_DESC;
        it.region_index = ridx;
        it.word_select  = wsel;
        it.word_value   = val;
        return it;
    endfunction

    // sender works in bursts with random gaps
    task automatic send_item(input t_in_item it);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        int          target;
        int          sel;
        int          r;
        int          n_settings;
        logic        avail;
        logic        en;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] acl_w;
        logic [31:0] vw;
        logic [31:0] span;
        logic [31:0] addr;
        t_region     rg;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_AVAIL;
        i_cfg_data  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            if (p > 0) wait_drained();
            case (p)
                0:       {avail, en} = 2'b11;
                1:       {avail, en} = 2'b01;
                2:       {avail, en} = 2'b10;
                3:       {avail, en} = 2'b00;
                default: {avail, en} = ($urandom_range(0, 3) == 0) ? 2'($urandom()) : 2'b11;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_AVAIL;
            i_cfg_data  <= avail;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_index <= CFG_ENABLE;
            i_cfg_data  <= en;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;

            if (p == 0) begin
                send_item(make_access(32'h0000_0000, 3'd0, 1'b0, ACC_READ));
                send_item(make_desc(4'd0, WSEL_START, 32'h0000_1000));
                send_item(make_desc(4'd0, WSEL_END,   32'h0000_1FFF));
                // master 0: user read only, supervisor rx; master 4: read enable
                send_item(make_desc(4'd0, WSEL_ACL,   32'h0200_000C));
                send_item(make_desc(4'd0, WSEL_VALID, 32'h0000_0001));
                send_item(make_access(32'h0000_1000, 3'd0, 1'b0, ACC_READ));
                send_item(make_access(32'h0000_1FFF, 3'd0, 1'b0, ACC_WRITE));
                send_item(make_access(32'h0000_2000, 3'd0, 1'b0, ACC_READ));
                send_item(make_access(32'h0000_1800, 3'd0, 1'b1, ACC_WRITE));
                send_item(make_access(32'h0000_1800, 3'd0, 1'b1, ACC_EXEC));
                send_item(make_access(32'h0000_1800, 3'd4, 1'b0, ACC_READ));
                send_item(make_access(32'h0000_1800, 3'd4, 1'b1, ACC_WRITE));
                send_item(make_access(32'h0000_1800, 3'd4, 1'b0, ACC_EXEC));
                send_item(make_access(32'h0000_1800, 3'd7, 1'b1, ACC_INVALID));
                send_item(make_desc(4'd12, WSEL_START, 32'hFFFF_FFFF));
                send_item(make_desc(4'd15, WSEL_VALID, 32'h0000_0001));
                // start above end: never matches
                send_item(make_desc(4'd1, WSEL_START, 32'h0000_8000));
                send_item(make_desc(4'd1, WSEL_END,   32'h0000_7FFF));
                send_item(make_desc(4'd1, WSEL_ACL,   32'hFFFF_FFFF));
                send_item(make_desc(4'd1, WSEL_VALID, 32'h0000_0001));
                send_item(make_access(32'h0000_8000, 3'd1, 1'b1, ACC_READ));
                send_item(make_desc(4'd2, WSEL_VALID, 32'h0000_0000));
                send_item(make_access(32'hFFFF_FFFF, 3'd3, 1'b1, ACC_EXEC));
            end

            target = n_sent + ((p == 0) ? 250 : (p < 4) ? 150 : 270);
            while (n_sent < target) begin
                sel = $urandom_range(0, 99);
                if (sel < 8) begin
                    r = $urandom_range(0, NUM_REGIONS - 1);
                    case ($urandom_range(0, 7))
                        0: begin lo = '0; hi = '1; end
                        1: begin lo = $urandom() | 32'h0000_1000; hi = lo - $urandom_range(1, 256); end
                        2: begin lo = $urandom(); hi = lo; end
                        3: begin lo = 32'hFFFF_F000; hi = '1; end
                        default: begin
                            lo = $urandom() & 32'hFFFF_FF00;
                            hi = lo + $urandom_range(0, 65535);
                        end
                    endcase
                    case ($urandom_range(0, 5))
                        0:       acl_w = '0;
                        1:       acl_w = '1;
                        default: acl_w = $urandom();
                    endcase
                    vw    = $urandom();
                    vw[0] = ($urandom_range(0, 4) != 0);
                    send_item(make_desc(4'(r), WSEL_START, lo));
                    send_item(make_desc(4'(r), WSEL_END,   hi));
                    send_item(make_desc(4'(r), WSEL_ACL,   acl_w));
                    send_item(make_desc(4'(r), WSEL_VALID, vw));
                end else if (sel < 12) begin
                    send_item(make_desc(4'($urandom()), 2'($urandom()), $urandom()));
                end else begin
                    rg   = sb.regions[$urandom_range(0, NUM_REGIONS - 1)];
                    span = rg.hi_addr - rg.lo_addr;
                    case ($urandom_range(0, 9))
                        0, 1:    addr = rg.lo_addr;
                        2:       addr = rg.hi_addr;
                        3:       addr = rg.lo_addr - 1;
                        4:       addr = rg.hi_addr + 1;
                        5, 6, 7: addr = rg.lo_addr + ((span == '1) ? $urandom()
                                                                  : $urandom() % (span + 1));
                        default: addr = $urandom();
                    endcase
                    send_item(make_access(addr, 3'($urandom()), 1'($urandom()),
                                          ($urandom_range(0, 9) == 0) ? ACC_INVALID
                                                                      : 2'($urandom_range(0, 2))));
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        n_settings = 0;
        foreach (sb.seen_setting[i]) n_settings += int'(sb.seen_setting[i]);
        $display("tb: %0d accesses (%0d allowed, %0d violations), %0d descriptor writes",
                 sb.n_access, sb.n_allowed, sb.n_violations, sb.n_desc);
        $display("tb: %0d results compared under %0d of 4 unit settings",
                 sb.n_results, n_settings);
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
rtl/mrac_pkg.sv
rtl/mrac_region_store.sv
rtl/mrac_match_unit.sv
rtl/mpu_region_access_check_unit.sv
rtl/mrac_checker.sv
tb/tb.sv
